### hdl/biq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biq_pkg: shared types and constants of the multichannel biquad
// Widths, fixed-point limits, register codes, sequencer states and the
// control word of the serial multipliers.
// ----------------------------------------------------------------------------
package biq_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 24;
	localparam int CHAN_BITS   = 3;
	localparam int COEF_BITS   = 24;
	localparam int FRAC_BITS   = 22;
	localparam int DELAY_BITS  = 48;

	localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
	localparam int SUM_BITS    = ((PROD_BITS > DELAY_BITS) ? PROD_BITS : DELAY_BITS) + 2;
	localparam int Y_WIDE_BITS = SUM_BITS - FRAC_BITS;

	// radix-4 serial multiplier: two multiplier bits per cycle
	localparam int MUL_DIGITS   = (SAMPLE_BITS + 1) / 2;
	localparam int MUL_LO_BITS  = 2 * MUL_DIGITS;
	localparam int MUL_HI_BITS  = COEF_BITS + 3;
	localparam int DIG_CNT_BITS = $clog2(MUL_DIGITS);
	localparam logic [DIG_CNT_BITS-1:0] DIG_LAST = DIG_CNT_BITS'(MUL_DIGITS - 1);

	localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_EXT_BITS = ((CHAN_BITS > CH_IDX_BITS) ? CHAN_BITS : CH_IDX_BITS) + 1;
	localparam logic [CH_EXT_BITS-1:0] CHANNELS_EXT = CH_EXT_BITS'(CHANNELS);

	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;
	localparam int REG_IDX_BITS  = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_B0 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_B1 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_B2 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_A1 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_A2 = 3'd4;

	// 1.0 in Q2.22
	localparam logic signed [COEF_BITS-1:0] COEF_ONE =
		{{(COEF_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
		{{(SUM_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [SUM_BITS-1:0] DLY_MAX =
		{{(SUM_BITS-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
	localparam logic signed [SUM_BITS-1:0] DLY_MIN =
		{{(SUM_BITS-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};
	localparam logic signed [Y_WIDE_BITS-1:0] Y_MAX =
		{{(Y_WIDE_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [Y_WIDE_BITS-1:0] Y_MIN =
		{{(Y_WIDE_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_X,
		ST_FORM_Y,
		ST_MUL_Y,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic last;
	} mul_ctl_t;

	function automatic logic chan_ok(input logic [CHAN_BITS-1:0] ch);
		logic [CH_EXT_BITS-1:0] ext;
		ext = {{(CH_EXT_BITS-CHAN_BITS){1'b0}}, ch};
		return ext < CHANNELS_EXT;
	endfunction

	function automatic logic [CH_IDX_BITS-1:0] chan_idx(input logic [CHAN_BITS-1:0] ch);
		logic [CH_EXT_BITS-1:0] ext;
		ext = {{(CH_EXT_BITS-CHAN_BITS){1'b0}}, ch};
		return ext[CH_IDX_BITS-1:0];
	endfunction

	function automatic logic signed [DELAY_BITS-1:0] sat_delay(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] c;
		c = v;
		if (v > DLY_MAX) begin
			c = DLY_MAX;
		end else if (v < DLY_MIN) begin
			c = DLY_MIN;
		end
		return c[DELAY_BITS-1:0];
	endfunction

endpackage
`default_nettype wire

### hdl/biquad_tdf2_multichannel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_tdf2_multichannel: multichannel biquad, transposed direct form II
// Per-channel delay pair, Q2.22 coefficients on an APB-style port,
// rounded and saturated output.
// ----------------------------------------------------------------------------
// One sample word is filtered at a time. From its acceptance until its result
// enters the output register, the radix-4 serial multipliers first form b0*x,
// b1*x and b2*x in parallel (ST_MUL_X), ST_FORM_Y forms and rounds y, a1*y and
// a2*y follow (ST_MUL_Y), ST_UPDATE writes the channel's delay pair and
// ST_DONE loads the result. A new word is taken only after that, back in
// ST_IDLE; a result not yet taken stalls the load and with it the input. The
// output register holds a finished result while the next word is taken.
// Coefficients sit at byte addresses 0, 4, 8, 12, 16 (b0, b1, b2, a1, a2) and
// reset to a pass-through filter; write them only while the block is idle.
// A channel number at or above CHANNELS yields zero and leaves state alone.
// ----------------------------------------------------------------------------
module biquad_tdf2_multichannel (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      in_valid,
	output logic                                           in_ready,
	input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0]    sample_in,
	input  wire logic        [biq_pkg::CHAN_BITS-1:0]      channel_in,
	output logic                                           out_valid,
	input  wire logic                                      out_ready,
	output logic signed [biq_pkg::SAMPLE_BITS-1:0]         sample_out,
	output logic        [biq_pkg::CHAN_BITS-1:0]           channel_out,
	input  wire logic                                      psel,
	input  wire logic                                      penable,
	input  wire logic                                      pwrite,
	input  wire logic        [biq_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic        [biq_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic             [biq_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                           pready
);

	// configuration
	logic signed [biq_pkg::COEF_BITS-1:0] coef_b0_q, coef_b1_q, coef_b2_q;
	logic signed [biq_pkg::COEF_BITS-1:0] coef_a1_q, coef_a2_q;
	logic        [biq_pkg::REG_IDX_BITS-1:0] reg_idx;
	logic                                    cfg_write;
	logic signed [biq_pkg::COEF_BITS-1:0]    rd_coef;

	// sequencer
	biq_pkg::state_t state_q, state_d;
	logic [biq_pkg::DIG_CNT_BITS-1:0] cnt_q;
	logic in_accept;
	logic dig_last;
	logic out_free;
	logic out_load;
	biq_pkg::mul_ctl_t ctl_ab, ctl_c;

	// datapath
	logic        [biq_pkg::CHAN_BITS-1:0]   ch_q;
	logic signed [biq_pkg::DELAY_BITS-1:0]  d1_q, d2_q;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] y_q;
	logic signed [biq_pkg::SUM_BITS-1:0]    s1_q, s2_q;
	logic signed [biq_pkg::DELAY_BITS-1:0]  delay_one_q [biq_pkg::CHANNELS];
	logic signed [biq_pkg::DELAY_BITS-1:0]  delay_two_q [biq_pkg::CHANNELS];
	logic        [biq_pkg::CH_IDX_BITS-1:0] in_idx, idx_q;
	logic                                   ch_ok;

	logic signed [biq_pkg::COEF_BITS-1:0]   mul_coef_a, mul_coef_b;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] mul_src;
	logic signed [biq_pkg::PROD_BITS-1:0]   prod_a, prod_b, prod_c;

	logic signed [biq_pkg::SUM_BITS-1:0]    acc_w;
	logic signed [biq_pkg::Y_WIDE_BITS-1:0] y_wide;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] y_next;
	logic signed [biq_pkg::SUM_BITS-1:0]    n1_w, n2_w;

	logic                                   out_valid_q;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_out_q;
	logic        [biq_pkg::CHAN_BITS-1:0]   channel_out_q;

	// ---------------------------------------------------------------- APB
	assign pready    = 1'b1;
	assign reg_idx   = paddr[biq_pkg::APB_ADDR_BITS-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= biq_pkg::COEF_ONE;
			coef_b1_q <= '0;
			coef_b2_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				biq_pkg::REG_B0: coef_b0_q <= pwdata[biq_pkg::COEF_BITS-1:0];
				biq_pkg::REG_B1: coef_b1_q <= pwdata[biq_pkg::COEF_BITS-1:0];
				biq_pkg::REG_B2: coef_b2_q <= pwdata[biq_pkg::COEF_BITS-1:0];
				biq_pkg::REG_A1: coef_a1_q <= pwdata[biq_pkg::COEF_BITS-1:0];
				biq_pkg::REG_A2: coef_a2_q <= pwdata[biq_pkg::COEF_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			biq_pkg::REG_B0: rd_coef = coef_b0_q;
			biq_pkg::REG_B1: rd_coef = coef_b1_q;
			biq_pkg::REG_B2: rd_coef = coef_b2_q;
			biq_pkg::REG_A1: rd_coef = coef_a1_q;
			biq_pkg::REG_A2: rd_coef = coef_a2_q;
			default:         rd_coef = '0;
		endcase
		prdata = {{(biq_pkg::APB_DATA_BITS-biq_pkg::COEF_BITS){rd_coef[biq_pkg::COEF_BITS-1]}},
			rd_coef};
	end

	// ---------------------------------------------------------------- sequencer
	assign dig_last  = (cnt_q == biq_pkg::DIG_LAST);
	assign out_free  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			biq_pkg::ST_IDLE: begin
				if (in_valid) state_d = biq_pkg::ST_MUL_X;
			end
			biq_pkg::ST_MUL_X: begin
				if (dig_last) state_d = biq_pkg::ST_FORM_Y;
			end
			biq_pkg::ST_FORM_Y: state_d = biq_pkg::ST_MUL_Y;
			biq_pkg::ST_MUL_Y: begin
				if (dig_last) state_d = biq_pkg::ST_UPDATE;
			end
			biq_pkg::ST_UPDATE: state_d = biq_pkg::ST_DONE;
			biq_pkg::ST_DONE: begin
				if (out_free) state_d = biq_pkg::ST_IDLE;
			end
			default: state_d = biq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_load    = 1'b0;
		ctl_ab      = '0;
		ctl_c       = '0;
		ctl_ab.last = dig_last;
		ctl_c.last  = dig_last;
		unique case (state_q)
			biq_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				ctl_ab.load = in_valid;
				ctl_c.load  = in_valid;
			end
			biq_pkg::ST_MUL_X: begin
				ctl_ab.step = 1'b1;
				ctl_c.step  = 1'b1;
			end
			biq_pkg::ST_FORM_Y: ctl_ab.load = 1'b1;
			biq_pkg::ST_MUL_Y:  ctl_ab.step = 1'b1;
			biq_pkg::ST_UPDATE: ;
			biq_pkg::ST_DONE:   out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= biq_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == biq_pkg::ST_MUL_X || state_q == biq_pkg::ST_MUL_Y) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- multipliers
	// units a and b take b0, b1 against x, then a1, a2 against y
	assign mul_coef_a = (state_q == biq_pkg::ST_FORM_Y) ? coef_a1_q : coef_b0_q;
	assign mul_coef_b = (state_q == biq_pkg::ST_FORM_Y) ? coef_a2_q : coef_b1_q;
	assign mul_src    = (state_q == biq_pkg::ST_FORM_Y) ? y_next : sample_in;

	biq_smul u_mul_a (
		.clk     (clk),
		.ctl     (ctl_ab),
		.coef    (mul_coef_a),
		.mplier  (mul_src),
		.product (prod_a)
	);

	biq_smul u_mul_b (
		.clk     (clk),
		.ctl     (ctl_ab),
		.coef    (mul_coef_b),
		.mplier  (mul_src),
		.product (prod_b)
	);

	biq_smul u_mul_c (
		.clk     (clk),
		.ctl     (ctl_c),
		.coef    (coef_b2_q),
		.mplier  (sample_in),
		.product (prod_c)
	);

	// ---------------------------------------------------------------- datapath
	assign in_idx = biq_pkg::chan_idx(channel_in);
	assign ch_ok  = biq_pkg::chan_ok(ch_q);

	// y = floor((b0*x + r1 + half) / 2^FRAC), then saturate
	always_comb begin
		acc_w = {{(biq_pkg::SUM_BITS-biq_pkg::PROD_BITS){prod_a[biq_pkg::PROD_BITS-1]}}, prod_a}
			+ {{(biq_pkg::SUM_BITS-biq_pkg::DELAY_BITS){d1_q[biq_pkg::DELAY_BITS-1]}}, d1_q}
			+ biq_pkg::ROUND_HALF;
		y_wide = acc_w[biq_pkg::SUM_BITS-1:biq_pkg::FRAC_BITS];
		if (!ch_ok) begin
			y_next = '0;
		end else if (y_wide > biq_pkg::Y_MAX) begin
			y_next = biq_pkg::Y_MAX[biq_pkg::SAMPLE_BITS-1:0];
		end else if (y_wide < biq_pkg::Y_MIN) begin
			y_next = biq_pkg::Y_MIN[biq_pkg::SAMPLE_BITS-1:0];
		end else begin
			y_next = y_wide[biq_pkg::SAMPLE_BITS-1:0];
		end
	end

	assign n1_w = s1_q
		- {{(biq_pkg::SUM_BITS-biq_pkg::PROD_BITS){prod_a[biq_pkg::PROD_BITS-1]}}, prod_a};
	assign n2_w = s2_q
		- {{(biq_pkg::SUM_BITS-biq_pkg::PROD_BITS){prod_b[biq_pkg::PROD_BITS-1]}}, prod_b};

	always_ff @(posedge clk) begin
		if (in_accept) begin
			ch_q  <= channel_in;
			idx_q <= in_idx;
			d1_q  <= delay_one_q[in_idx];
			d2_q  <= delay_two_q[in_idx];
		end
		if (state_q == biq_pkg::ST_FORM_Y) begin
			y_q  <= y_next;
			s1_q <= {{(biq_pkg::SUM_BITS-biq_pkg::PROD_BITS){prod_b[biq_pkg::PROD_BITS-1]}},
				prod_b}
				+ {{(biq_pkg::SUM_BITS-biq_pkg::DELAY_BITS){d2_q[biq_pkg::DELAY_BITS-1]}}, d2_q};
			s2_q <= {{(biq_pkg::SUM_BITS-biq_pkg::PROD_BITS){prod_c[biq_pkg::PROD_BITS-1]}},
				prod_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < biq_pkg::CHANNELS; i++) begin
				delay_one_q[i] <= '0;
				delay_two_q[i] <= '0;
			end
		end else if (state_q == biq_pkg::ST_UPDATE && ch_ok) begin
			delay_one_q[idx_q] <= biq_pkg::sat_delay(n1_w);
			delay_two_q[idx_q] <= biq_pkg::sat_delay(n2_w);
		end
	end

	// ---------------------------------------------------------------- output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q  <= y_q;
			channel_out_q <= ch_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;

`ifndef ASSERT_OFF
	a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> !in_ready)
		else $error("new word taken while one is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a word not yet taken");

	a_mul_x_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == biq_pkg::ST_MUL_X) && dig_last |=> (state_q == biq_pkg::ST_FORM_Y))
		else $error("multiply phase did not end after the last digit");

	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !ch_ok |=> (sample_out == '0))
		else $error("out-of-range channel gave a nonzero sample");
`endif

endmodule
`default_nettype wire

### hdl/biq_smul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biq_smul: radix-4 serial signed multiplier
// Shifts the multiplier out two bits per cycle and adds 0, 1, 2 or 3 times
// the coefficient into a narrow high half; the top digit carries the sign.
// ----------------------------------------------------------------------------
module biq_smul (
	input  wire logic                                   clk,
	input  wire biq_pkg::mul_ctl_t                      ctl,
	input  wire logic signed [biq_pkg::COEF_BITS-1:0]   coef,
	input  wire logic signed [biq_pkg::SAMPLE_BITS-1:0] mplier,
	output logic signed [biq_pkg::PROD_BITS-1:0]        product
);

	logic signed [biq_pkg::MUL_HI_BITS-1:0] hi_q;
	logic        [biq_pkg::MUL_LO_BITS-1:0] lo_q;
	logic signed [biq_pkg::COEF_BITS-1:0]   coef_q;

	logic signed [biq_pkg::MUL_HI_BITS-1:0] m1;
	logic signed [biq_pkg::MUL_HI_BITS-1:0] m2;
	logic signed [biq_pkg::MUL_HI_BITS-1:0] addend;
	logic signed [biq_pkg::MUL_HI_BITS-1:0] sum_w;
	logic        [biq_pkg::SAMPLE_BITS:0]   mplier_ext;
	logic        [biq_pkg::MUL_HI_BITS+biq_pkg::MUL_LO_BITS-1:0] full_w;

	assign m1 = {{(biq_pkg::MUL_HI_BITS-biq_pkg::COEF_BITS){coef_q[biq_pkg::COEF_BITS-1]}},
		coef_q};
	assign m2 = {m1[biq_pkg::MUL_HI_BITS-2:0], 1'b0};
	assign mplier_ext = {mplier[biq_pkg::SAMPLE_BITS-1], mplier};

	// upper bit of the last digit has negative weight
	always_comb begin
		addend = '0;
		if (lo_q[0]) begin
			addend = m1;
		end
		if (lo_q[1]) begin
			addend = ctl.last ? (addend - m2) : (addend + m2);
		end
		sum_w = hi_q + addend;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			hi_q   <= '0;
			lo_q   <= mplier_ext[biq_pkg::MUL_LO_BITS-1:0];
			coef_q <= coef;
		end else if (ctl.step) begin
			hi_q <= {{2{sum_w[biq_pkg::MUL_HI_BITS-1]}}, sum_w[biq_pkg::MUL_HI_BITS-1:2]};
			lo_q <= {sum_w[1:0], lo_q[biq_pkg::MUL_LO_BITS-1:2]};
		end
	end

	assign full_w  = {hi_q, lo_q};
	assign product = full_w[biq_pkg::PROD_BITS-1:0];

endmodule
`default_nettype wire

### tb/biquad_tdf2_multichannel_test.sv
// ----------------------------------------------------------------------------
// biquad_tdf2_multichannel_test: self-checking bench of the multichannel biquad
// Streams sample words into the filter under several coefficient sets, computes
// each filtered word in a local fixed-point model and compares it with the
// block's output word. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module biquad_tdf2_multichannel_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_WORDS    = 154;

	localparam logic [biq_pkg::REG_IDX_BITS-1:0] REG_UNUSED = 3'd5;

	localparam logic signed [biq_pkg::COEF_BITS-1:0] COEF_MAX =
		{1'b0, {(biq_pkg::COEF_BITS-1){1'b1}}};
	localparam logic signed [biq_pkg::COEF_BITS-1:0] COEF_MIN =
		{1'b1, {(biq_pkg::COEF_BITS-1){1'b0}}};
	localparam logic signed [biq_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX =
		{1'b0, {(biq_pkg::SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [biq_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN =
		{1'b1, {(biq_pkg::SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [biq_pkg::SAMPLE_BITS-1:0] sample;
		logic [biq_pkg::CHAN_BITS-1:0]   channel;
	} audio_word_t;

	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SLOW,
		RX_PATTERN
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_in = '0;
	logic [biq_pkg::CHAN_BITS-1:0] channel_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [biq_pkg::SAMPLE_BITS-1:0] sample_out;
	logic [biq_pkg::CHAN_BITS-1:0] channel_out;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [biq_pkg::APB_ADDR_BITS-1:0] paddr = '0;
	logic [biq_pkg::APB_DATA_BITS-1:0] pwdata = '0;
	logic [biq_pkg::APB_DATA_BITS-1:0] prdata;
	logic pready;

	biquad_tdf2_multichannel uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.channel_in(channel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.channel_out(channel_out),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// local copy of coefficients and per-channel delay pairs
	logic signed [biq_pkg::COEF_BITS-1:0] cf_b0 = biq_pkg::COEF_ONE;
	logic signed [biq_pkg::COEF_BITS-1:0] cf_b1 = '0;
	logic signed [biq_pkg::COEF_BITS-1:0] cf_b2 = '0;
	logic signed [biq_pkg::COEF_BITS-1:0] cf_a1 = '0;
	logic signed [biq_pkg::COEF_BITS-1:0] cf_a2 = '0;
	logic signed [biq_pkg::DELAY_BITS-1:0] dly_one [biq_pkg::CHANNELS];
	logic signed [biq_pkg::DELAY_BITS-1:0] dly_two [biq_pkg::CHANNELS];

	audio_word_t samples_to_send [$];
	audio_word_t filtered_due [$];
	audio_word_t next_word;
	audio_word_t want;

	logic in_took = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int hold_runs = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int mode_left = 0;
	logic [7:0] stall_pattern = 8'h01;
	int idle_cycles = 0;
	int fail_count = 0;
	int checked_count = 0;
	int sent_count = 0;
	int coef_sets = 0;

	initial begin
		for (int i = 0; i < biq_pkg::CHANNELS; i++) begin
			dly_one[i] = '0;
			dly_two[i] = '0;
		end
	end

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// filter one word and advance that channel's delay pair
	function automatic audio_word_t biquad_next(
			input logic signed [biq_pkg::SAMPLE_BITS-1:0] x,
			input logic [biq_pkg::CHAN_BITS-1:0] ch);
		audio_word_t r;
		longint acc;
		longint y;
		longint n1;
		longint n2;
		r.channel = ch;
		r.sample = '0;
		if (int'(ch) < biq_pkg::CHANNELS) begin
			acc = longint'(cf_b0) * longint'(x) + longint'(dly_one[ch]);
			// round half up, then clamp to the sample range
			y = clip((acc + (longint'(1) <<< (biq_pkg::FRAC_BITS - 1))) >>> biq_pkg::FRAC_BITS,
				biq_pkg::SAMPLE_BITS);
			n1 = longint'(cf_b1) * longint'(x) - longint'(cf_a1) * y + longint'(dly_two[ch]);
			n2 = longint'(cf_b2) * longint'(x) - longint'(cf_a2) * y;
			dly_one[ch] = biq_pkg::DELAY_BITS'(clip(n1, biq_pkg::DELAY_BITS));
			dly_two[ch] = biq_pkg::DELAY_BITS'(clip(n2, biq_pkg::DELAY_BITS));
			r.sample = biq_pkg::SAMPLE_BITS'(y);
		end
		return r;
	endfunction

	task automatic write_coef(input logic [biq_pkg::REG_IDX_BITS-1:0] idx,
			input logic signed [biq_pkg::COEF_BITS-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(biq_pkg::APB_DATA_BITS-biq_pkg::COEF_BITS){value[biq_pkg::COEF_BITS-1]}},
			value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			biq_pkg::REG_B0: cf_b0 = value;
			biq_pkg::REG_B1: cf_b1 = value;
			biq_pkg::REG_B2: cf_b2 = value;
			biq_pkg::REG_A1: cf_a1 = value;
			biq_pkg::REG_A2: cf_a2 = value;
			default: ;
		endcase
	endtask

	task automatic program_filter(input logic signed [biq_pkg::COEF_BITS-1:0] b0,
			input logic signed [biq_pkg::COEF_BITS-1:0] b1,
			input logic signed [biq_pkg::COEF_BITS-1:0] b2,
			input logic signed [biq_pkg::COEF_BITS-1:0] a1,
			input logic signed [biq_pkg::COEF_BITS-1:0] a2);
		write_coef(biq_pkg::REG_B0, b0);
		write_coef(biq_pkg::REG_B1, b1);
		write_coef(biq_pkg::REG_B2, b2);
		write_coef(biq_pkg::REG_A1, a1);
		write_coef(biq_pkg::REG_A2, a2);
		coef_sets++;
	endtask

	task automatic queue_sample(input logic signed [biq_pkg::SAMPLE_BITS-1:0] s,
			input logic [biq_pkg::CHAN_BITS-1:0] ch);
		audio_word_t w;
		w.sample = s;
		w.channel = ch;
		samples_to_send.push_back(w);
	endtask

	// hold until every word is sent and every result is back, then let the pipe drain
	task automatic settle();
		while (samples_to_send.size() != 0 || in_valid || filtered_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [biq_pkg::SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return biq_pkg::SAMPLE_BITS'(int'($urandom_range(0, 4000)) - 2000);
			default: return biq_pkg::SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// sender: bursts of words with random gaps
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (gap_left > 0 || samples_to_send.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end else begin
				next_word = samples_to_send.pop_front();
				in_valid <= 1'b1;
				sample_in <= next_word.sample;
				channel_in <= next_word.channel;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// receiver: stall pattern changes now and then; a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
			hold_runs++;
		end
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 300);
			stall_pattern = 8'($urandom) | 8'h01;
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					out_ready <= stall_pattern[0];
					stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
				end
			endcase
		end
	end

	// check output words, predict from accepted input words
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (filtered_due.size() == 0) begin
					$error("sample_out: expected nothing, got %0d on channel %0d",
						sample_out, channel_out);
					fail_count++;
				end else begin
					want = filtered_due.pop_front();
					checked_count++;
					if (sample_out !== want.sample) begin
						$error("sample_out: expected %0d, got %0d",
							$signed(want.sample), sample_out);
						fail_count++;
					end
					if (channel_out !== want.channel) begin
						$error("channel_out: expected %0d, got %0d", want.channel, channel_out);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				filtered_due.push_back(biquad_next(sample_in, channel_in));
				sent_count++;
			end
		end
		in_took <= arst_n && in_valid && in_ready;
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("biquad_tdf2_multichannel_test: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int lim;
		int b0;
		int b1;
		int b2;
		int a1;
		int a2;
		logic [biq_pkg::CHAN_BITS-1:0] ch;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pass-through after reset: extremes and small values, one word on every channel
		queue_sample(SAMPLE_MAX, 0);
		queue_sample(SAMPLE_MIN, 1);
		queue_sample(0, 2);
		queue_sample(-1, 3);
		queue_sample(1, 4);
		queue_sample(SAMPLE_MAX, 5);
		queue_sample(SAMPLE_MIN, 6);
		queue_sample(24'sh555555, 7);
		settle();

		// b0 of one LSB: exercises round-half-up on ties
		program_filter(1, 0, 0, 0, 0);
		queue_sample(24'sd2097152, 0);
		queue_sample(-24'sd2097152, 1);
		queue_sample(-24'sd2097153, 2);
		queue_sample(24'sd6291456, 3);
		queue_sample(-24'sd6291456, 4);
		queue_sample(24'sd2097151, 5);
		settle();

		// extreme coefficients: output and delay registers saturate
		program_filter(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
		// a write past the last register must change nothing
		write_coef(REG_UNUSED, 24'sh123456);
		queue_sample(SAMPLE_MAX, 3);
		queue_sample(SAMPLE_MAX, 3);
		queue_sample(SAMPLE_MAX, 3);
		queue_sample(SAMPLE_MIN, 4);
		queue_sample(SAMPLE_MIN, 4);
		queue_sample(SAMPLE_MAX, 4);
		queue_sample(0, 3);
		queue_sample(0, 4);
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				1: program_filter(24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom));
				2: program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
				3: program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
				4: program_filter(biq_pkg::COEF_ONE, 0, 0, 0, 0);
				default: begin
					// stable filter: |a2| < 1 and |a1| < 1 + a2
					a2 = $urandom_range(0, 3774873);
					lim = (4194304 + a2) * 9 / 10;
					a1 = int'($urandom_range(0, 2 * lim)) - lim;
					b0 = int'($urandom_range(0, 4194304)) - 2097152;
					b1 = int'($urandom_range(0, 4194304)) - 2097152;
					b2 = int'($urandom_range(0, 4194304)) - 2097152;
					program_filter(biq_pkg::COEF_BITS'(b0), biq_pkg::COEF_BITS'(b1),
						biq_pkg::COEF_BITS'(b2), biq_pkg::COEF_BITS'(a1),
						biq_pkg::COEF_BITS'(a2));
				end
			endcase
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// runs on one channel now and then, otherwise mixed
				ch = ($urandom_range(0, 3) == 0) ? biq_pkg::CHAN_BITS'(phase)
					: biq_pkg::CHAN_BITS'($urandom);
				queue_sample(pick_sample(), ch);
			end
			if (phase == 1 || phase == 5) hold_req = 1'b1;
			settle();
		end

		$display("covered %0d sample words on %0d coefficient sets, %0d long output stalls",
			sent_count, coef_sets, hold_runs);
		$display("%0d output words compared, %0d mismatches", checked_count, fail_count);
		if (fail_count == 0) begin
			$display("biquad_tdf2_multichannel_test: done, clean");
		end else begin
			$display("biquad_tdf2_multichannel_test: done, errors");
		end
		$finish;
	end

endmodule
